// ===== design/prebuffered_audio_jitter_buffer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the prebuffered audio jitter buffer
// Each macro expands to a clocked concurrent assertion in simulation and to
// nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef PREBUFFERED_AUDIO_JITTER_BUFFER_ASSERT_SVH
`define PREBUFFERED_AUDIO_JITTER_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication: whenever ante holds, cons must hold too.
`define PAJB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define PAJB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PAJB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define PAJB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/pajb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pajb_pkg
// Shared sizes, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pajb_pkg;

    // Ring and frame cache sizes.
    localparam int RING_DEPTH  = 65536;
    localparam int CACHE_DEPTH = 2048;

    // Derived widths.
    localparam int RING_AW  = $clog2(RING_DEPTH);
    localparam int FILL_W   = $clog2(CACHE_DEPTH + 1);
    localparam int CACHE_AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CHR_W    = FILL_W;
    localparam int THR_W    = 16;
    localparam int CMP_W    = (RING_AW > THR_W) ? RING_AW : THR_W;
    localparam int SAMPLE_W = 32;
    localparam int OP_W     = 2;

    // Prebuffer threshold after reset.
    localparam logic [THR_W-1:0] THR_RESET = 16'd4096;

    // Operation codes of an input item.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_PULL  = 2'd1,
        OP_DRAIN = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture_in;
        logic exec_push;
        logic exec_drain;
        logic exec_pull;
        logic refill_start;
        logic copy_issue;
        logic cache_rd;
        logic serve_capture;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic cache_empty;
        logic prebuf_after;
        logic copy_done;
        logic out_free;
    } ctrl_status_t;

endpackage

// ===== design/pajb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pajb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pajb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                           aclk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic                                           re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/pajb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pajb_ctrl
// Controller state machine: sequences one item through execute, cache
// refill, cache read and result hand-off.
// ----------------------------------------------------------------------------
module pajb_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  pajb_pkg::ctrl_status_t  st,
    output pajb_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_COPY,
        S_READ,
        S_SERVE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;

    // Command decode and next state.
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.capture_in = 1'b1;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                unique case (st.op)
                    pajb_pkg::OP_PUSH: begin
                        cmd.exec_push = 1'b1;
                    end
                    pajb_pkg::OP_PULL: begin
                        cmd.exec_pull = 1'b1;
                        if (st.cache_empty) begin
                            // Refill decision: copy only once prebuffering is over.
                            cmd.refill_start = 1'b1;
                            state_next       = st.prebuf_after ? S_DONE : S_COPY;
                        end else begin
                            cmd.cache_rd = 1'b1;
                            state_next   = S_SERVE;
                        end
                    end
                    pajb_pkg::OP_DRAIN: begin
                        cmd.exec_drain = 1'b1;
                    end
                    pajb_pkg::OP_NOP: begin
                    end
                    default: begin
                    end
                endcase
            end
            S_COPY: begin
                cmd.copy_issue = 1'b1;
                if (st.copy_done) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.cache_rd = 1'b1;
                state_next   = S_SERVE;
            end
            S_SERVE: begin
                cmd.serve_capture = 1'b1;
                state_next        = S_DONE;
            end
            S_DONE: begin
                if (st.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

// ===== design/pajb_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pajb_dp
// Datapath: ring and frame cache memories, indices, prebuffer hysteresis,
// chrono countdown, result staging and the output register.
// ----------------------------------------------------------------------------
module pajb_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [pajb_pkg::OP_W-1:0]           s_op,
    input  logic [pajb_pkg::SAMPLE_W-1:0]       s_sample_in,
    input  logic                                cfg_valid,
    input  logic [pajb_pkg::THR_W-1:0]          cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_accepted,
    output logic [pajb_pkg::SAMPLE_W-1:0]       m_sample_out,
    output logic                                m_sample_valid,
    output logic                                m_buffering,
    output logic                                m_chrono_due,
    input  pajb_pkg::ctrl_cmd_t                 cmd,
    output pajb_pkg::ctrl_status_t              st
);

    // Control registers.
    logic [pajb_pkg::THR_W-1:0]    thr_reg, thr_next;
    logic [pajb_pkg::RING_AW-1:0]  wi_reg, wi_next;
    logic [pajb_pkg::RING_AW-1:0]  ri_reg, ri_next;
    logic [pajb_pkg::FILL_W-1:0]   fill_reg, fill_next;
    logic [pajb_pkg::FILL_W-1:0]   cache_next_reg, cache_next_next;
    logic [pajb_pkg::FILL_W-1:0]   issue_cnt_reg, issue_cnt_next;
    logic [pajb_pkg::CHR_W-1:0]    chrono_reg, chrono_next;
    logic                          prebuf_reg, prebuf_next;
    logic                          wr_pend_reg, wr_pend_next;
    logic                          out_valid_reg, out_valid_next;

    // Item and result registers.
    pajb_pkg::op_t                 op_reg;
    logic [pajb_pkg::SAMPLE_W-1:0] sample_reg;
    logic                          res_acc_reg;
    logic [pajb_pkg::SAMPLE_W-1:0] res_sample_reg;
    logic                          res_valid_reg;
    logic                          res_due_reg;
    logic                          out_acc_reg;
    logic [pajb_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic                          out_svalid_reg;
    logic                          out_buf_reg;
    logic                          out_due_reg;

    // Combinational helpers.
    logic [pajb_pkg::RING_AW-1:0]  wi_inc;
    logic [pajb_pkg::RING_AW-1:0]  avail;
    logic                          ring_full;
    logic                          avail_zero;
    logic                          avail_ge;
    logic                          prebuf_after;
    logic                          can_issue;
    logic                          issue;
    logic                          chrono_hit;
    logic                          ring_we;
    logic [pajb_pkg::SAMPLE_W-1:0] ring_rdata;
    logic [pajb_pkg::SAMPLE_W-1:0] cache_rdata;

    // Ring occupancy and hysteresis decision.
    assign wi_inc       = wi_reg + 1'b1;
    assign ring_full    = (wi_inc == ri_reg);
    assign avail        = wi_reg - ri_reg;
    assign avail_zero   = (avail == '0);
    assign avail_ge     = (pajb_pkg::CMP_W'(avail) >= pajb_pkg::CMP_W'(thr_reg));
    assign prebuf_after = avail_zero || (prebuf_reg && !avail_ge);

    // Copy issue: stop after one frame or when the ring runs dry.
    assign can_issue = (issue_cnt_reg < pajb_pkg::FILL_W'(pajb_pkg::CACHE_DEPTH))
                       && (ri_reg != wi_reg);
    assign issue      = cmd.copy_issue && can_issue;
    assign chrono_hit = (chrono_reg <= pajb_pkg::CHR_W'(1));
    assign ring_we    = cmd.exec_push && !ring_full;

    // Status to the controller.
    assign st.op           = op_reg;
    assign st.cache_empty  = (cache_next_reg == fill_reg);
    assign st.prebuf_after = prebuf_after;
    assign st.copy_done    = !can_issue && !wr_pend_reg;
    assign st.out_free     = !out_valid_reg || m_ready;

    // Sample ring.
    pajb_ram #(
        .WIDTH (pajb_pkg::SAMPLE_W),
        .DEPTH (pajb_pkg::RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (wi_reg),
        .wdata (sample_reg),
        .re    (issue),
        .raddr (ri_reg),
        .rdata (ring_rdata)
    );

    // Frame cache, written in the cycle after each ring read.
    pajb_ram #(
        .WIDTH (pajb_pkg::SAMPLE_W),
        .DEPTH (pajb_pkg::CACHE_DEPTH)
    ) u_cache (
        .aclk  (aclk),
        .we    (wr_pend_reg),
        .waddr (fill_reg[pajb_pkg::CACHE_AW-1:0]),
        .wdata (ring_rdata),
        .re    (cmd.cache_rd),
        .raddr (cache_next_reg[pajb_pkg::CACHE_AW-1:0]),
        .rdata (cache_rdata)
    );

    // Next values of the control registers.
    always_comb begin
        thr_next        = thr_reg;
        wi_next         = wi_reg;
        ri_next         = ri_reg;
        fill_next       = fill_reg;
        cache_next_next = cache_next_reg;
        issue_cnt_next  = issue_cnt_reg;
        chrono_next     = chrono_reg;
        prebuf_next     = prebuf_reg;
        wr_pend_next    = issue;
        out_valid_next  = out_valid_reg;

        if (cfg_valid) begin
            thr_next = cfg_data;
        end
        if (ring_we) begin
            wi_next = wi_inc;
        end
        if (cmd.exec_drain) begin
            wi_next         = '0;
            ri_next         = '0;
            fill_next       = '0;
            cache_next_next = '0;
        end
        if (cmd.exec_pull) begin
            chrono_next = chrono_hit ? pajb_pkg::CHR_W'(pajb_pkg::CACHE_DEPTH)
                                     : chrono_reg - 1'b1;
        end
        if (cmd.refill_start) begin
            fill_next       = '0;
            cache_next_next = '0;
            issue_cnt_next  = '0;
            prebuf_next     = prebuf_after;
        end
        if (issue) begin
            ri_next        = ri_reg + 1'b1;
            issue_cnt_next = issue_cnt_reg + 1'b1;
        end
        if (wr_pend_reg) begin
            fill_next = fill_reg + 1'b1;
        end
        if (cmd.serve_capture) begin
            cache_next_next = cache_next_reg + 1'b1;
        end
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg        <= pajb_pkg::THR_RESET;
            wi_reg         <= '0;
            ri_reg         <= '0;
            fill_reg       <= '0;
            cache_next_reg <= '0;
            issue_cnt_reg  <= '0;
            chrono_reg     <= pajb_pkg::CHR_W'(1);
            prebuf_reg     <= 1'b1;
            wr_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            thr_reg        <= thr_next;
            wi_reg         <= wi_next;
            ri_reg         <= ri_next;
            fill_reg       <= fill_next;
            cache_next_reg <= cache_next_next;
            issue_cnt_reg  <= issue_cnt_next;
            chrono_reg     <= chrono_next;
            prebuf_reg     <= prebuf_next;
            wr_pend_reg    <= wr_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Item capture, result staging and output payload.
    always_ff @(posedge aclk) begin
        if (cmd.capture_in) begin
            op_reg         <= pajb_pkg::op_t'(s_op);
            sample_reg     <= s_sample_in;
            res_acc_reg    <= 1'b0;
            res_sample_reg <= '0;
            res_valid_reg  <= 1'b0;
            res_due_reg    <= 1'b0;
        end
        if (cmd.exec_push) begin
            res_acc_reg <= !ring_full;
        end
        if (cmd.exec_pull) begin
            res_due_reg <= chrono_hit;
        end
        if (cmd.serve_capture) begin
            res_sample_reg <= cache_rdata;
            res_valid_reg  <= 1'b1;
        end
        if (cmd.load_out) begin
            out_acc_reg    <= res_acc_reg;
            out_sample_reg <= res_sample_reg;
            out_svalid_reg <= res_valid_reg;
            out_buf_reg    <= prebuf_reg;
            out_due_reg    <= res_due_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_accepted     = out_acc_reg;
    assign m_sample_out   = out_sample_reg;
    assign m_sample_valid = out_svalid_reg;
    assign m_buffering    = out_buf_reg;
    assign m_chrono_due   = out_due_reg;

endmodule

// ===== design/prebuffered_audio_jitter_buffer.sv =====
`timescale 1ns / 1ps
`include "prebuffered_audio_jitter_buffer_assert.svh"
// ----------------------------------------------------------------------------
// prebuffered_audio_jitter_buffer
// Transmit audio jitter buffer: sample ring with a frame cache and prebuffer
// hysteresis.
// ----------------------------------------------------------------------------
// Each input item is a push, a pull, a drain or a no-op, and each gives one
// result item. One item is in work at a time. A push, drain or no-op passes
// through the execute and done states; a pull served from the frame cache
// adds a serve state. A pull that finds the cache empty and ends prebuffering
// refills the cache at one sample per cycle through the ring read port, up to
// one frame, in a copy state, then reads and serves the first sample; a pull
// that finds the ring still prebuffering goes straight to done. The
// result sits in an output register, so the next item is accepted while it
// waits to be taken. The prebuffer threshold may be written at any time the
// block is idle; the memories need no clearing after reset.
module prebuffered_audio_jitter_buffer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pajb_pkg::OP_W-1:0]       s_op,
    input  logic [pajb_pkg::SAMPLE_W-1:0]   s_sample_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_accepted,
    output logic [pajb_pkg::SAMPLE_W-1:0]   m_sample_out,
    output logic                            m_sample_valid,
    output logic                            m_buffering,
    output logic                            m_chrono_due,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pajb_pkg::THR_W-1:0]      cfg_data
);

    pajb_pkg::ctrl_cmd_t    cmd;
    pajb_pkg::ctrl_status_t st;

    // The threshold register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    // Controller.
    pajb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // Datapath.
    pajb_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_op           (s_op),
        .s_sample_in    (s_sample_in),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_accepted     (m_accepted),
        .m_sample_out   (m_sample_out),
        .m_sample_valid (m_sample_valid),
        .m_buffering    (m_buffering),
        .m_chrono_due   (m_chrono_due),
        .cmd            (cmd),
        .st             (st)
    );

    // An accepted item closes the input until its work is done.
    `PAJB_ASSERT_NEXT(a_accept_closes, aclk, aresetn, s_valid && s_ready, !s_ready, "input stayed open after an item was accepted")
    // A result is loaded only when the output register can take it.
    `PAJB_ASSERT_IMPLY(a_load_free, aclk, aresetn, cmd.load_out, st.out_free, "result loaded over a waiting result")
    // The frame cache is read only when it holds an unserved sample.
    `PAJB_ASSERT_IMPLY(a_cache_rd_full, aclk, aresetn, cmd.cache_rd, !st.cache_empty, "frame cache read while empty")

endmodule

// ===== bench/prebuffered_audio_jitter_buffer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prebuffered_audio_jitter_buffer_tb
// Self-checking bench for the transmit audio jitter buffer. A behavioral copy
// of the ring, frame cache, prebuffer hysteresis and chrono countdown predicts
// every reply; the bench walks through directed corner cases, a deep fill
// that is played out in one long refill burst, and burst-shaped random
// traffic at several thresholds.
// ----------------------------------------------------------------------------
module prebuffered_audio_jitter_buffer_tb;
    import pajb_pkg::*;

    localparam logic [THR_W-1:0] THR_MAX = 16'hFFFF;

    // One reply item as the block presents it.
    typedef struct packed {
        logic                accepted;
        logic [SAMPLE_W-1:0] sample_out;
        logic                sample_valid;
        logic                buffering;
        logic                chrono_due;
    } reply_t;

    // Clock and block ports.
    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_op           = OP_NOP;
    logic [SAMPLE_W-1:0] s_sample_in    = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic                m_accepted;
    logic [SAMPLE_W-1:0] m_sample_out;
    logic                m_sample_valid;
    logic                m_buffering;
    logic                m_chrono_due;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [THR_W-1:0]    cfg_data       = '0;

    // Shadow state of the jitter buffer, starting from its reset values.
    logic [SAMPLE_W-1:0] ring_copy  [0:RING_DEPTH-1];
    logic [SAMPLE_W-1:0] cache_copy [0:CACHE_DEPTH-1];
    logic [RING_AW-1:0]  wr_ptr      = '0;
    logic [RING_AW-1:0]  rd_ptr      = '0;
    logic [FILL_W-1:0]   cache_count = '0;
    logic [FILL_W-1:0]   play_idx    = '0;
    logic                prebuf_on   = 1'b1;
    logic [CHR_W-1:0]    frame_left  = CHR_W'(1);
    logic [THR_W-1:0]    resume_level = THR_RESET;

    // Replies predicted for accepted items, oldest first.
    reply_t pending_replies[$];

    // Run control and statistics.
    bit steady        = 1'b0;
    int stall_request = 0;
    int hold_left     = 0;
    int errors        = 0;
    int items_sent    = 0;
    int replies_seen  = 0;
    int dropped_pushes = 0;
    int cache_refills = 0;
    int chrono_pulses = 0;

    prebuffered_audio_jitter_buffer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_sample_in    (s_sample_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_accepted     (m_accepted),
        .m_sample_out   (m_sample_out),
        .m_sample_valid (m_sample_valid),
        .m_buffering    (m_buffering),
        .m_chrono_due   (m_chrono_due),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    // Free-running clock with an 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Works out the reply to one accepted item and advances the shadow state.
    task automatic predict_reply(input op_t op, input logic [SAMPLE_W-1:0] smp);
        reply_t             r;
        logic [RING_AW-1:0] nxt;
        logic [RING_AW-1:0] avail;
        r = '0;
        case (op)
            OP_PUSH: begin
                nxt = wr_ptr + 1'b1;
                if (nxt != rd_ptr) begin
                    ring_copy[wr_ptr] = smp;
                    wr_ptr = nxt;
                    r.accepted = 1'b1;
                end else begin
                    dropped_pushes++;
                end
            end
            OP_PULL: begin
                if (frame_left <= CHR_W'(1)) begin
                    r.chrono_due = 1'b1;
                    frame_left = CHR_W'(CACHE_DEPTH);
                    chrono_pulses++;
                end else begin
                    frame_left = frame_left - 1'b1;
                end
                // An exhausted cache is refilled from the ring, with hysteresis.
                if (play_idx >= cache_count) begin
                    play_idx = '0;
                    cache_count = '0;
                    avail = wr_ptr - rd_ptr;
                    if (avail == '0) begin
                        prebuf_on = 1'b1;
                    end else if (avail >= resume_level) begin
                        prebuf_on = 1'b0;
                    end
                    if (!prebuf_on) begin
                        cache_refills++;
                        while (cache_count < CACHE_DEPTH && rd_ptr != wr_ptr) begin
                            cache_copy[cache_count] = ring_copy[rd_ptr];
                            cache_count = cache_count + 1'b1;
                            rd_ptr = rd_ptr + 1'b1;
                        end
                    end
                end
                if (play_idx < cache_count) begin
                    r.sample_out = cache_copy[play_idx];
                    r.sample_valid = 1'b1;
                    play_idx = play_idx + 1'b1;
                end
            end
            OP_DRAIN: begin
                wr_ptr = '0;
                rd_ptr = '0;
                cache_count = '0;
                play_idx = '0;
            end
            default: begin
            end
        endcase
        r.buffering = prebuf_on;
        pending_replies.push_back(r);
    endtask

    // Offers one item, with random idle cycles first outside steady stretches, and records it once taken.
    task automatic send_item(input op_t op, input logic [SAMPLE_W-1:0] smp);
        while (!steady && $urandom_range(0, 99) < 11) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_sample_in <= smp;
        do @(posedge aclk); while (!s_ready);
        predict_reply(op, smp);
        items_sent++;
    endtask

    // Stops offering items and waits until every predicted reply has arrived.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Writes the prebuffer threshold while the block is idle.
    task automatic write_threshold(input logic [THR_W-1:0] level);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= level;
        do @(posedge aclk); while (!cfg_ready);
        resume_level = level;
        cfg_valid <= 1'b0;
    endtask

    // Reports one reply field that differs from its prediction.
    task automatic check_field(input string name, input logic [SAMPLE_W-1:0] want,
                               input logic [SAMPLE_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Receiver side: random back-pressure, steady stretches and long holds.
    always @(posedge aclk) begin
        if (stall_request > 0) begin
            hold_left = stall_request;
            stall_request = 0;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 11);
        end
    end

    // Compares every accepted reply with the oldest prediction.
    always @(posedge aclk) begin : reply_check
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            replies_seen++;
            if (pending_replies.size() == 0) begin
                $display("%0t ns: reply with none expected, actual %h %h %b %b %b", $time,
                         m_accepted, m_sample_out, m_sample_valid, m_buffering, m_chrono_due);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                check_field("accepted", want.accepted, m_accepted);
                check_field("sample_out", want.sample_out, m_sample_out);
                check_field("sample_valid", want.sample_valid, m_sample_valid);
                check_field("buffering", want.buffering, m_buffering);
                check_field("chrono_due", want.chrono_due, m_chrono_due);
            end
        end
    end

    // Behavior straight out of reset at the default threshold.
    task automatic test_after_reset();
        send_item(OP_PULL, 32'h0000_0000);
        send_item(OP_NOP, 32'hFFFF_FFFF);
        send_item(OP_DRAIN, 32'h0000_0000);
        send_item(OP_PUSH, 32'h0000_0000);
        send_item(OP_PUSH, 32'hFFFF_FFFF);
        // Two samples stay far below the threshold, so the pull answers zero.
        send_item(OP_PULL, 32'hFFFF_FFFF);
    endtask

    // Lowest thresholds, including zero, and a pull on an empty ring.
    task automatic test_threshold_edges();
        write_threshold(16'd1);
        send_item(OP_PULL, 32'h0000_0000);
        send_item(OP_PULL, 32'h0000_0000);
        // Cache and ring both empty: prebuffering starts again.
        send_item(OP_PULL, 32'h0000_0000);
        send_item(OP_PUSH, 32'h8000_0000);
        send_item(OP_PULL, 32'h0000_0000);
        send_item(OP_DRAIN, 32'hFFFF_FFFF);
        send_item(OP_PULL, 32'h0000_0000);
        write_threshold(16'd0);
        send_item(OP_PUSH, 32'h7FFF_FFFF);
        send_item(OP_PULL, 32'h0000_0000);
        send_item(OP_NOP, 32'h0000_0000);
    endtask

    // Hysteresis: playback resumes only at the threshold, stops only when empty.
    task automatic test_hysteresis();
        write_threshold(16'd3);
        send_item(OP_PUSH, 32'h3F80_0000);
        send_item(OP_PUSH, 32'hBF80_0000);
        send_item(OP_PULL, 32'h0000_0000);
        send_item(OP_PUSH, 32'h3F00_0000);
        send_item(OP_PULL, 32'h0000_0000);
        send_item(OP_PULL, 32'h0000_0000);
        send_item(OP_PUSH, 32'hBF00_0000);
        send_item(OP_PULL, 32'h0000_0000);
        // The ring is now empty, so this pull starts prebuffering again and answers zero.
        send_item(OP_PULL, 32'h0000_0000);
        send_item(OP_PULL, 32'h0000_0000);
    endtask

    // Fills the ring deeply, holds it at the maximum threshold, then plays it
    // out in one long refill burst until the ring runs dry.
    task automatic test_deep_fill();
        int k;
        write_threshold(THR_MAX);
        steady = 1'b1;
        send_item(OP_DRAIN, $urandom());
        // A pull on the empty ring puts the block back into prebuffering.
        send_item(OP_PULL, $urandom());
        for (k = 0; k < 300; k++) begin
            send_item(OP_PUSH, $urandom());
        end
        // Far below the maximum threshold, so these pulls answer zero.
        repeat (4) send_item(OP_PULL, $urandom());
        steady = 1'b0;
        write_threshold(16'd250);
        // The first pull moves all 300 samples into the cache at once.
        for (k = 0; k < 310; k++) begin
            send_item(OP_PULL, $urandom());
        end
        send_item(OP_DRAIN, $urandom());
        send_item(OP_PULL, $urandom());
    endtask

    // Bursts of pushes and pulls with noise, over several threshold levels.
    task automatic test_random_traffic();
        int               phase;
        int               taken;
        int               burst;
        int               j;
        int               roll;
        bit               push_heavy;
        op_t              op;
        logic [THR_W-1:0] level;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: level = 16'd1;
                1: level = 16'($urandom_range(2, 16));
                2: level = 16'($urandom_range(17, 96));
                3: level = 16'($urandom_range(97, 300));
                4: level = 16'($urandom_range(1, 40));
                default: level = 16'($urandom_range(1, 8));
            endcase
            write_threshold(level);
            // Hold the receiver off while items keep coming, so the input stalls.
            if (phase == 2) stall_request = 300;
            steady = (phase == 4);
            taken = 0;
            while (taken < 130) begin
                if (phase == 3) push_heavy = ($urandom_range(0, 99) < 70);
                else push_heavy = ($urandom_range(0, 1) == 1);
                burst = $urandom_range(1, 48);
                for (j = 0; j < burst; j++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 4) op = OP_NOP;
                    else if (roll < 6) op = OP_DRAIN;
                    else if ((roll < 91) == push_heavy) op = OP_PUSH;
                    else op = OP_PULL;
                    send_item(op, $urandom());
                    if (op != OP_NOP) taken++;
                end
            end
        end
        steady = 1'b0;
    endtask

    // Main sequence.
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_after_reset();
        test_threshold_edges();
        test_hysteresis();
        test_deep_fill();
        test_random_traffic();
        wait_drained();
        repeat (2100) @(posedge aclk);
        $display("Sent %0d items and checked %0d replies at thresholds 0, 1, 3, 250,",
                 items_sent, replies_seen);
        $display("4096, 65535 and random levels.");
        $display("Run saw %0d dropped pushes, %0d frame refills and %0d chrono pulses.",
                 dropped_pushes, cache_refills, chrono_pulses);
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("prebuffered_audio_jitter_buffer_tb passed");
        end else begin
            $display("prebuffered_audio_jitter_buffer_tb failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(24_000_000);
        $display("Timeout with %0d replies still expected.", pending_replies.size());
        $display("prebuffered_audio_jitter_buffer_tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/pajb_pkg.sv
design/pajb_ram.sv
design/pajb_ctrl.sv
design/pajb_dp.sv
design/prebuffered_audio_jitter_buffer.sv
bench/prebuffered_audio_jitter_buffer_tb.sv
